// ===== rtl/cyk_pkg.sv =====
// ----------------------------------------------------------------------------
// cyk_pkg
// Shared types and codes of the CYK grammar recognizer.
// ----------------------------------------------------------------------------
package cyk_pkg;

    localparam int SYM_W          = 5;
    localparam int TERMINAL_COUNT = 26;
    localparam int START_INDEX    = 18;

    localparam logic [1:0] REQ_UNARY  = 2'd0;
    localparam logic [1:0] REQ_BINARY = 2'd1;
    localparam logic [1:0] REQ_CHAR   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [SYM_W-1:0] head_symbol;
        logic [SYM_W-1:0] first_symbol;
        logic [SYM_W-1:0] second_symbol;
        logic [SYM_W-1:0] terminal;
        logic             is_last;
    } t_in_word;

    typedef struct packed {
        logic accepted;
        logic too_long;
    } t_out_word;

endpackage

// ===== rtl/cyk_ram.sv =====
// ----------------------------------------------------------------------------
// cyk_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cyk_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/cyk_grammar_recognizer.sv =====
// ----------------------------------------------------------------------------
// cyk_grammar_recognizer
// CYK recognizer for a grammar in Chomsky normal form.
// ----------------------------------------------------------------------------
// Input words add a unary rule, add a binary rule, clear the grammar or push
// one string character. A binary rule is a read-modify-write of both operand
// orders in the binary rule RAM. Clear runs a clearing pass over the binary
// rule RAM, one entry a cycle. The same pass runs after reset, during which
// no word is accepted. The last character starts the chart build: each leaf
// cell is filled from the text RAM; each chart cell reads its left and right
// cells at every split point, looks up every pair of derived symbols in the
// binary rule RAM and is then written; last the top cell is read. Every step
// goes through the one chart RAM port and one binary rule RAM port. A
// too-long string skips the chart build. One result word per string; while
// it waits for i_out_ready the block takes new words, but holds a new result
// until the pending one is taken.
// ----------------------------------------------------------------------------
module cyk_grammar_recognizer #(
    parameter int MAX_LEN     = 64,
    parameter int NUM_SYMBOLS = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cyk_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cyk_pkg::t_out_word  o_out_word
);

    localparam int NS  = NUM_SYMBOLS;
    localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int BD  = NS * NS;
    localparam int BAW = $clog2(BD);
    localparam int CD  = 2 ** (2 * LW);
    localparam int SW  = cyk_pkg::SYM_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_B_RD1, S_B_WR1, S_B_RD2, S_B_WR2,
        S_LEAF_RD, S_LEAF_WR, S_SPL_RDL, S_SPL_RDR, S_SPL_GET,
        S_PAIR_RD, S_PAIR_ACC, S_CELL_WR, S_FIN_RD, S_FIN_GET
    } t_state;

    t_state           r_state, n_state;
    logic [NS-1:0]    r_unary [cyk_pkg::TERMINAL_COUNT];
    logic [CW-1:0]    r_len, n_len;
    logic             r_ovf, n_ovf;
    logic             r_tl, n_tl;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_slen, n_slen;
    logic [LW-1:0]    r_i, n_i;
    logic [LW-1:0]    r_k, n_k;
    logic [BAW-1:0]   r_baddr, n_baddr;
    logic [BAW-1:0]   r_baddr2, n_baddr2;
    logic [NS-1:0]    r_bbit, n_bbit;
    logic [NS-1:0]    r_left, n_left;
    logic [NS-1:0]    r_right, n_right;
    logic [NS-1:0]    r_lrem, n_lrem;
    logic [NS-1:0]    r_rrem, n_rrem;
    logic [NS-1:0]    r_acc, n_acc;
    logic             r_ovalid, n_ovalid;
    cyk_pkg::t_out_word r_oword, n_oword;

    logic             w_in_acc;
    logic [LW-1:0]    w_j;
    logic [SW-1:0]    w_a, w_b;
    logic [NS-1:0]    w_rrem_left;

    logic             w_b_we;
    logic [BAW-1:0]   w_b_waddr, w_b_raddr;
    logic [NS-1:0]    w_b_wdata, w_b_rdata;
    logic             w_t_we;
    logic [LW-1:0]    w_t_raddr;
    logic [SW-1:0]    w_t_rdata;
    logic             w_c_we;
    logic [2*LW-1:0]  w_c_waddr, w_c_raddr;
    logic [NS-1:0]    w_c_wdata, w_c_rdata;

    function automatic logic [SW-1:0] f_low(input logic [NS-1:0] m);
        logic [SW-1:0] idx;
        idx = '0;
        for (int q = NS - 1; q >= 0; q--) begin
            if (m[q]) begin
                idx = SW'(q);
            end
        end
        return idx;
    endfunction

    cyk_ram #(.W(NS), .D(BD)) u_bin (
        .i_clk(i_clk), .i_we(w_b_we), .i_waddr(w_b_waddr), .i_wdata(w_b_wdata),
        .i_raddr(w_b_raddr), .o_rdata(w_b_rdata)
    );

    cyk_ram #(.W(SW), .D(MAX_LEN)) u_text (
        .i_clk(i_clk), .i_we(w_t_we), .i_waddr(r_len[LW-1:0]),
        .i_wdata(i_in_word.terminal), .i_raddr(w_t_raddr), .o_rdata(w_t_rdata)
    );

    cyk_ram #(.W(NS), .D(CD)) u_chart (
        .i_clk(i_clk), .i_we(w_c_we), .i_waddr(w_c_waddr), .i_wdata(w_c_wdata),
        .i_raddr(w_c_raddr), .o_rdata(w_c_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    assign w_j         = LW'(CW'(r_i) + r_slen - CW'(1));
    assign w_a         = f_low(r_lrem);
    assign w_b         = f_low(r_rrem);
    assign w_rrem_left = r_rrem & ~(NS'(1) << w_b);

    assign w_t_we    = w_in_acc && (i_in_word.req_type == cyk_pkg::REQ_CHAR)
                       && (r_len < CW'(MAX_LEN));
    assign w_t_raddr = r_i;

    always_comb begin
        w_b_we    = 1'b0;
        w_b_waddr = r_baddr;
        w_b_wdata = w_b_rdata | r_bbit;
        w_b_raddr = r_baddr;
        w_c_we    = 1'b0;
        w_c_waddr = {r_i, w_j};
        w_c_wdata = r_acc;
        w_c_raddr = {r_i, r_k};
        unique case (r_state)
            S_CLEAR: begin
                w_b_we    = 1'b1;
                w_b_wdata = '0;
            end
            S_B_WR1, S_B_WR2: w_b_we = 1'b1;
            S_LEAF_WR: begin
                w_c_we    = 1'b1;
                w_c_waddr = {r_i, r_i};
                w_c_wdata = (w_t_rdata < SW'(cyk_pkg::TERMINAL_COUNT))
                            ? r_unary[w_t_rdata] : '0;
            end
            S_SPL_RDR: w_c_raddr = {LW'(r_k + LW'(1)), w_j};
            S_PAIR_RD: w_b_raddr = BAW'(BAW'(w_a) * BAW'(NS) + BAW'(w_b));
            S_CELL_WR: w_c_we = 1'b1;
            S_FIN_RD, S_FIN_GET: w_c_raddr = {LW'(0), LW'(r_n - CW'(1))};
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_tl     = r_tl;
        n_n      = r_n;
        n_slen   = r_slen;
        n_i      = r_i;
        n_k      = r_k;
        n_baddr  = r_baddr;
        n_baddr2 = r_baddr2;
        n_bbit   = r_bbit;
        n_left   = r_left;
        n_right  = r_right;
        n_lrem   = r_lrem;
        n_rrem   = r_rrem;
        n_acc    = r_acc;
        n_ovalid = r_ovalid && !i_out_ready;
        n_oword  = r_oword;
        unique case (r_state)
            S_CLEAR: begin
                n_baddr = BAW'(r_baddr + BAW'(1));
                if (r_baddr == BAW'(BD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_word.req_type)
                        cyk_pkg::REQ_BINARY: begin
                            n_bbit   = NS'(1) << i_in_word.head_symbol;
                            n_baddr  = BAW'(BAW'(i_in_word.first_symbol) * BAW'(NS)
                                       + BAW'(i_in_word.second_symbol));
                            n_baddr2 = BAW'(BAW'(i_in_word.second_symbol) * BAW'(NS)
                                       + BAW'(i_in_word.first_symbol));
                            if (i_in_word.head_symbol < SW'(NS)
                                && i_in_word.first_symbol < SW'(NS)
                                && i_in_word.second_symbol < SW'(NS)) begin
                                n_state = S_B_RD1;
                            end
                        end
                        cyk_pkg::REQ_CLEAR: begin
                            n_baddr = '0;
                            n_state = S_CLEAR;
                        end
                        cyk_pkg::REQ_CHAR: begin
                            if (r_len < CW'(MAX_LEN)) begin
                                n_len = CW'(r_len + CW'(1));
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_in_word.is_last) begin
                                if (r_len == CW'(MAX_LEN) || r_ovf) begin
                                    n_tl    = 1'b1;
                                    n_n     = CW'(1);
                                    n_state = S_FIN_GET;
                                end else begin
                                    n_tl    = 1'b0;
                                    n_n     = CW'(r_len + CW'(1));
                                    n_i     = '0;
                                    n_state = S_LEAF_RD;
                                end
                                n_len = '0;
                                n_ovf = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_B_RD1: n_state = S_B_WR1;
            S_B_WR1: begin
                n_baddr = r_baddr2;
                n_state = S_B_RD2;
            end
            S_B_RD2: n_state = S_B_WR2;
            S_B_WR2: n_state = S_IDLE;
            S_LEAF_RD: n_state = S_LEAF_WR;
            S_LEAF_WR: begin
                if (CW'(r_i) + CW'(1) < r_n) begin
                    n_i     = LW'(r_i + LW'(1));
                    n_state = S_LEAF_RD;
                end else if (r_n >= CW'(2)) begin
                    n_slen  = CW'(2);
                    n_i     = '0;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = S_SPL_RDL;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_SPL_RDL: n_state = S_SPL_RDR;
            S_SPL_RDR: begin
                n_left  = w_c_rdata;
                n_state = S_SPL_GET;
            end
            S_SPL_GET: begin
                n_right = w_c_rdata;
                n_lrem  = r_left;
                n_rrem  = w_c_rdata;
                if (r_left == '0 || w_c_rdata == '0) begin
                    if (r_k + LW'(1) < w_j) begin
                        n_k     = LW'(r_k + LW'(1));
                        n_state = S_SPL_RDL;
                    end else begin
                        n_state = S_CELL_WR;
                    end
                end else begin
                    n_state = S_PAIR_RD;
                end
            end
            S_PAIR_RD: begin
                if (w_rrem_left == '0) begin
                    n_lrem = r_lrem & ~(NS'(1) << w_a);
                    n_rrem = r_right;
                end else begin
                    n_rrem = w_rrem_left;
                end
                n_state = S_PAIR_ACC;
            end
            S_PAIR_ACC: begin
                n_acc = r_acc | w_b_rdata;
                if (r_lrem != '0) begin
                    n_state = S_PAIR_RD;
                end else if (r_k + LW'(1) < w_j) begin
                    n_k     = LW'(r_k + LW'(1));
                    n_state = S_SPL_RDL;
                end else begin
                    n_state = S_CELL_WR;
                end
            end
            S_CELL_WR: begin
                n_acc = '0;
                if ((CW + 1)'(r_i) + (CW + 1)'(r_slen) + (CW + 1)'(1)
                    <= (CW + 1)'(r_n)) begin
                    n_i     = LW'(r_i + LW'(1));
                    n_k     = LW'(r_i + LW'(1));
                    n_state = S_SPL_RDL;
                end else if (r_slen < r_n) begin
                    n_slen  = CW'(r_slen + CW'(1));
                    n_i     = '0;
                    n_k     = '0;
                    n_state = S_SPL_RDL;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_FIN_RD: n_state = S_FIN_GET;
            S_FIN_GET: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oword  = '{accepted: !r_tl
                                     && |(w_c_rdata & (NS'(1) << cyk_pkg::START_INDEX)),
                                 too_long: r_tl};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_baddr  <= '0;
            r_ovalid <= 1'b0;
            for (int t = 0; t < cyk_pkg::TERMINAL_COUNT; t++) begin
                r_unary[t] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_baddr  <= n_baddr;
            r_ovalid <= n_ovalid;
            if (w_in_acc && i_in_word.req_type == cyk_pkg::REQ_CLEAR) begin
                for (int t = 0; t < cyk_pkg::TERMINAL_COUNT; t++) begin
                    r_unary[t] <= '0;
                end
            end else if (w_in_acc && i_in_word.req_type == cyk_pkg::REQ_UNARY
                         && i_in_word.head_symbol < SW'(NS)
                         && i_in_word.terminal < SW'(cyk_pkg::TERMINAL_COUNT)) begin
                r_unary[i_in_word.terminal] <= r_unary[i_in_word.terminal]
                                               | (NS'(1) << i_in_word.head_symbol);
            end
        end
        r_tl     <= n_tl;
        r_n      <= n_n;
        r_slen   <= n_slen;
        r_i      <= n_i;
        r_k      <= n_k;
        r_baddr2 <= n_baddr2;
        r_bbit   <= n_bbit;
        r_left   <= n_left;
        r_right  <= n_right;
        r_lrem   <= n_lrem;
        r_rrem   <= n_rrem;
        r_acc    <= n_acc;
        r_oword  <= n_oword;
    end

endmodule
